FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the tracker modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

FILE: rtl/core/mpevt_pkg.sv
// Shared types and constants for the MPE voice state tracker.
// No dependencies.
`default_nettype none
package mpevt_pkg;
  localparam int Voices = 16;
  localparam int SlotW = $clog2(Voices);

  localparam logic [3:0] StNoteOff = 4'h8;
  localparam logic [3:0] StNoteOn = 4'h9;
  localparam logic [3:0] StPolyPress = 4'hA;
  localparam logic [3:0] StCtrl = 4'hB;
  localparam logic [3:0] StChanPress = 4'hD;
  localparam logic [3:0] StBend = 4'hE;

  localparam logic [6:0] CcAllOff = 7'd121;
  localparam logic [6:0] CcSlide = 7'd74;
  localparam logic [6:0] CcMod = 7'd1;
  localparam logic [6:0] CcNrpnMsb = 7'd99;
  localparam logic [6:0] CcNrpnLsb = 7'd98;
  localparam logic [6:0] CcDataMsb = 7'd6;
  localparam logic [6:0] CcDataLsb = 7'd38;

  localparam logic [6:0] NoteReset = 7'd60;
  localparam logic [13:0] BendReset = 14'd8192;

  localparam logic [0:0] AddrMode = 1'b0;
  localparam logic [0:0] AddrSelect = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_APPLY, S_SCAN, S_REPORT, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan_step;
    logic take_slot;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic scan_hit;
    logic scan_last;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/mpevt_ctrl.sv
// Controller state machine for the voice tracker.
// Depends on mpevt_pkg.
`default_nettype none
module mpevt_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire mpevt_pkg::stat_t stat,
  output mpevt_pkg::cmd_t cmd
);
  mpevt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mpevt_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      mpevt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = mpevt_pkg::S_APPLY;
        end
      end
      mpevt_pkg::S_APPLY: begin
        if (stat.is_search) state_next = mpevt_pkg::S_SCAN;
        else begin
          cmd.apply = 1'b1;
          state_next = mpevt_pkg::S_REPORT;
        end
      end
      mpevt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          cmd.take_slot = 1'b1;
          state_next = mpevt_pkg::S_REPORT;
        end
      end
      mpevt_pkg::S_REPORT: begin
        cmd.report = 1'b1;
        state_next = mpevt_pkg::S_OUT;
      end
      mpevt_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = mpevt_pkg::S_APPLY;
          end else state_next = mpevt_pkg::S_IDLE;
        end
      end
      default: state_next = mpevt_pkg::S_IDLE;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_take_in_scan, clk, rst, cmd.take_slot |-> state == mpevt_pkg::S_SCAN)
  `ASSERT_CLK(a_out_after_report, clk, rst, (state == mpevt_pkg::S_OUT && $past(state) != mpevt_pkg::S_OUT) |-> $past(state) == mpevt_pkg::S_REPORT)
  `ASSERT_CLK(a_load_ready, clk, rst, cmd.load |-> in_ready && in_valid)
endmodule
`default_nettype wire

FILE: rtl/core/mpevt_dp.sv
// Datapath for the voice tracker: slot registers, rotation search, NRPN decoder.
// Depends on mpevt_pkg.
`default_nettype none
module mpevt_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mpevt_pkg::cmd_t cmd,
  output mpevt_pkg::stat_t stat,
  input  wire logic mode_pc,
  input  wire logic [13:0] nsel,
  input  wire logic in_func,
  input  wire logic [3:0] in_status,
  input  wire logic [3:0] in_ch,
  input  wire logic [6:0] in_d1,
  input  wire logic [6:0] in_d2,
  output logic [15:0] gate_mask,
  output logic [3:0] slot,
  output logic [6:0] note_out,
  output logic [6:0] strike_out,
  output logic [6:0] lift_out,
  output logic [6:0] press_out,
  output logic [6:0] slide_out,
  output logic [6:0] mod_out,
  output logic [13:0] bend_out,
  output logic [13:0] nrpn_value,
  output logic nrpn_match
);
  localparam int V = mpevt_pkg::Voices;
  localparam int SW = mpevt_pkg::SlotW;
  localparam logic [SW-1:0] Last = SW'(V - 1);

  logic func;
  logic [3:0] status, ch;
  logic [6:0] d1, d2;
  logic [6:0] s_note [V], s_strike [V], s_lift [V], s_press [V], s_slide [V], s_mod [V];
  logic [13:0] s_bend [V];
  logic [V-1:0] s_gate;
  logic [SW-1:0] rot, probe;
  logic [SW:0] scan_cnt;
  logic [3:0] rep;
  logic [6:0] parts [4];
  logic [3:0] have;
  logic [SW-1:0] chs;
  logic ch_ok, is_on;
  logic [1:0] pidx;
  logic pvalid;
  logic [3:0] have_new;
  logic [6:0] p0, p1;
  logic [3:0] rep_next;
  logic [13:0] nrpn_data_q;
  logic led;

  assign ch_ok = 32'(ch) < V;
  assign chs = ch[SW-1:0];
  assign is_on = !func && status == mpevt_pkg::StNoteOn && d2 != 7'd0;
  assign probe = (rot == Last) ? '0 : rot + 1'b1;
  assign stat.is_search = is_on && !mode_pc;
  assign stat.scan_hit = !s_gate[probe];
  assign stat.scan_last = 32'(scan_cnt) == V;

  always_comb begin
    pvalid = ch == 4'd0;
    pidx = 2'd0;
    case (d1)
      mpevt_pkg::CcNrpnMsb: pidx = 2'd0;
      mpevt_pkg::CcNrpnLsb: pidx = 2'd1;
      mpevt_pkg::CcDataMsb: pidx = 2'd2;
      mpevt_pkg::CcDataLsb: pidx = 2'd3;
      default: pvalid = 1'b0;
    endcase
    have_new = have | (4'd1 << pidx);
    p0 = (pidx == 2'd0) ? d2 : parts[0];
    p1 = (pidx == 2'd1) ? d2 : parts[1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      status <= in_status;
      ch <= in_ch;
      d1 <= in_d1;
      d2 <= in_d2;
      scan_cnt <= '0;
    end
    if (cmd.scan_step) scan_cnt <= scan_cnt + 1'b1;
    if (cmd.report) begin
      gate_mask <= 16'(s_gate);
      slot <= rep;
      if (32'(rep) < V) begin
        note_out <= s_note[rep[SW-1:0]];
        strike_out <= s_strike[rep[SW-1:0]];
        lift_out <= s_lift[rep[SW-1:0]];
        press_out <= s_press[rep[SW-1:0]];
        slide_out <= s_slide[rep[SW-1:0]];
        mod_out <= s_mod[rep[SW-1:0]];
        bend_out <= s_bend[rep[SW-1:0]];
      end else begin
        note_out <= '0; strike_out <= '0; lift_out <= '0; press_out <= '0;
        slide_out <= '0; mod_out <= '0; bend_out <= '0;
      end
      nrpn_value <= 14'(0) | nrpn_data_q;
      nrpn_match <= led;
    end
  end

  always_comb begin
    rep_next = rep;
    if (cmd.load) rep_next = '0;
    else if (cmd.apply) begin
      if (func) rep_next = ch;
      else if (is_on && mode_pc && ch_ok) rep_next = ch;
    end else if (cmd.take_slot) rep_next = 4'(probe);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot <= Last;
      have <= '0;
      nrpn_data_q <= '0;
      led <= 1'b0;
      rep <= '0;
      s_gate <= '0;
      for (int i = 0; i < 4; i++) parts[i] <= '0;
      for (int i = 0; i < V; i++) begin
        s_note[i] <= mpevt_pkg::NoteReset;
        s_strike[i] <= '0; s_lift[i] <= '0; s_press[i] <= '0;
        s_slide[i] <= '0; s_mod[i] <= '0;
        s_bend[i] <= mpevt_pkg::BendReset;
      end
    end else begin
      rep <= rep_next;
      if (cmd.scan_step) rot <= probe;
      if (cmd.take_slot) begin
        s_note[probe] <= d1;
        s_gate[probe] <= 1'b1;
        s_strike[probe] <= d2;
      end
      if (cmd.apply && !func) begin
        case (status)
          mpevt_pkg::StNoteOff, mpevt_pkg::StNoteOn: begin
            if (status == mpevt_pkg::StNoteOn && d2 != 7'd0) begin
              if (ch_ok) begin
                s_note[chs] <= d1;
                s_gate[chs] <= 1'b1;
                s_strike[chs] <= d2;
              end
            end else begin
              for (int i = 0; i < V; i++) if (s_note[i] == d1) begin
                s_gate[i] <= 1'b0;
                s_lift[i] <= (status == mpevt_pkg::StNoteOn) ? 7'd0 : d2;
              end
            end
          end
          mpevt_pkg::StPolyPress: begin
            if (mode_pc) begin
              if (ch_ok) s_press[chs] <= d2;
            end else
              for (int i = 0; i < V; i++) if (s_note[i] == d1) s_press[i] <= d2;
          end
          mpevt_pkg::StChanPress: begin
            if (mode_pc) begin
              if (ch_ok) s_press[chs] <= d1;
            end else
              for (int i = 0; i < V; i++) s_press[i] <= d1;
          end
          mpevt_pkg::StBend: begin
            if (mode_pc) begin
              if (ch_ok) s_bend[chs] <= {d2, d1};
            end else s_bend[0] <= {d2, d1};
          end
          mpevt_pkg::StCtrl: begin
            if (d1 == mpevt_pkg::CcAllOff) begin
              for (int i = 0; i < V; i++) s_slide[i] <= '0;
              nrpn_data_q <= '0;
            end
            if (d1 == mpevt_pkg::CcSlide && ch_ok) s_slide[chs] <= d2;
            if (d1 == mpevt_pkg::CcMod) begin
              if (mode_pc) begin
                if (ch_ok) s_mod[chs] <= d2;
              end else s_mod[0] <= d2;
            end else if (pvalid) begin
              parts[pidx] <= d2;
              if (have_new == 4'hF) begin
                if ({p0, p1} != nsel) begin
                  led <= 1'b0;
                  have <= have_new;
                end else begin
                  led <= 1'b1;
                  nrpn_data_q <= {(pidx == 2'd2) ? d2 : parts[2],
                                  (pidx == 2'd3) ? d2 : parts[3]};
                  have <= '0;
                end
              end else begin
                led <= 1'b0;
                have <= have_new;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_take_free, clk, rst, (cmd.take_slot && !stat.scan_last) |-> stat.scan_hit)
  `ASSERT_CLK(a_take_gate, clk, rst, cmd.take_slot |=> s_gate[$past(probe)])
  `ASSERT_CLK(a_scan_only_search, clk, rst, cmd.scan_step |-> stat.is_search)
endmodule
`default_nettype wire

FILE: rtl/core/mpe_midi_voice_state_tracker_core.sv
// Top level of the MPE voice state tracker: APB registers, controller, datapath.
// Depends on mpevt_pkg, mpevt_ctrl, mpevt_dp.
//  channel | signals                          | direction
//  input   | in_valid/in_ready + fields       | in
//  output  | out_valid/out_ready + fields     | out
//  config  | APB psel..prdata                 | in/out
// A result is valid after its input transfer passes the apply and report steps. A
// rotative note-on adds a slot scan between them, one slot per cycle through the
// gate search.
// Reset is synchronous and restores every slot at once; no clearing pass.
// A result is held until taken; a new item is accepted in that same cycle.
`default_nettype none
module mpe_midi_voice_state_tracker_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic func,
  input  wire logic [3:0] status,
  input  wire logic [3:0] midi_channel,
  input  wire logic [6:0] data1,
  input  wire logic [6:0] data2,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [15:0] gate_mask,
  output logic [3:0] slot,
  output logic [6:0] note_out,
  output logic [6:0] strike_out,
  output logic [6:0] lift_out,
  output logic [6:0] press_out,
  output logic [6:0] slide_out,
  output logic [6:0] mod_out,
  output logic [13:0] bend_out,
  output logic [13:0] nrpn_value,
  output logic nrpn_match
);
  logic mode_pc;
  logic [13:0] nsel;
  mpevt_pkg::cmd_t cmd;
  mpevt_pkg::stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_pc <= 1'b1;
      nsel <= 14'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (paddr[2])
        mpevt_pkg::AddrMode: mode_pc <= pwdata[0];
        mpevt_pkg::AddrSelect: nsel <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mpevt_pkg::AddrMode: prdata = {31'd0, mode_pc};
      mpevt_pkg::AddrSelect: prdata = {18'd0, nsel};
      default: prdata = '0;
    endcase
  end

  mpevt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  mpevt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .mode_pc(mode_pc), .nsel(nsel),
    .in_func(func), .in_status(status), .in_ch(midi_channel), .in_d1(data1),
    .in_d2(data2), .gate_mask(gate_mask), .slot(slot), .note_out(note_out),
    .strike_out(strike_out), .lift_out(lift_out), .press_out(press_out),
    .slide_out(slide_out), .mod_out(mod_out), .bend_out(bend_out),
    .nrpn_value(nrpn_value), .nrpn_match(nrpn_match)
  );
endmodule
`default_nettype wire

FILE: sim/mpe_midi_voice_state_tracker_core_test.sv
// Testbench for mpe_midi_voice_state_tracker_core: drives MIDI messages and register writes,
// predicts every result with a voice-slot model, and compares field by field.
// Depends on mpevt_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

class voice_tracker_board;
  bit mode_mpe;
  bit [13:0] nrpn_sel;
  bit [6:0] note[16];
  bit gate[16];
  bit [6:0] strike[16];
  bit [6:0] lift[16];
  bit [6:0] press[16];
  bit [6:0] slide[16];
  bit [6:0] modw[16];
  bit [13:0] bend[16];
  bit [3:0] rot_ptr;
  bit [6:0] parts[4];
  bit [3:0] have;
  bit [13:0] nrpn_word;
  bit led;
  bit [90:0] pending[$];
  int errors;

  function void clear();
    mode_mpe = 1;
    nrpn_sel = 1;
    for (int i = 0; i < 16; i++) begin
      note[i] = mpevt_pkg::NoteReset;
      gate[i] = 0;
      strike[i] = 0;
      lift[i] = 0;
      press[i] = 0;
      slide[i] = 0;
      modw[i] = 0;
      bend[i] = mpevt_pkg::BendReset;
    end
    rot_ptr = 15;
    for (int i = 0; i < 4; i++) parts[i] = 0;
    have = 0;
    nrpn_word = 0;
    led = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void release_note(bit [6:0] n, bit [6:0] v);
    for (int i = 0; i < 16; i++)
      if (note[i] == n) begin
        gate[i] = 0;
        lift[i] = v;
      end
  endfunction

  function void nrpn_step(bit [3:0] ch, bit [6:0] cc, bit [6:0] v);
    int p;
    if (ch != 0) return;
    case (cc)
      mpevt_pkg::CcNrpnMsb: p = 0;
      mpevt_pkg::CcNrpnLsb: p = 1;
      mpevt_pkg::CcDataMsb: p = 2;
      mpevt_pkg::CcDataLsb: p = 3;
      default: return;
    endcase
    parts[p] = v;
    have[p] = 1;
    if (have == 4'hF) begin
      if ({parts[0], parts[1]} != nrpn_sel) led = 0;
      else begin
        led = 1;
        nrpn_word = {parts[2], parts[3]};
        have = 0;
      end
    end else led = 0;
  endfunction

  function void note_item(bit f, bit [3:0] st, bit [3:0] ch, bit [6:0] d1, bit [6:0] d2);
    bit [3:0] rep;
    bit [15:0] mask;
    bit hit;
    rep = 0;
    if (f) rep = ch;
    else case (st)
      mpevt_pkg::StNoteOff: release_note(d1, d2);
      mpevt_pkg::StNoteOn:
        if (d2 == 0) release_note(d1, 0);
        else begin
          rep = ch;
          if (!mode_mpe) begin
            hit = 0;
            for (int k = 0; k < 16 && !hit; k++) begin
              rot_ptr = rot_ptr + 4'd1;
              if (!gate[rot_ptr]) hit = 1;
            end
            if (!hit) rot_ptr = rot_ptr + 4'd1;
            rep = rot_ptr;
          end
          note[rep] = d1;
          gate[rep] = 1;
          strike[rep] = d2;
        end
      mpevt_pkg::StPolyPress:
        if (mode_mpe) press[ch] = d2;
        else for (int i = 0; i < 16; i++) if (note[i] == d1) press[i] = d2;
      mpevt_pkg::StChanPress:
        if (mode_mpe) press[ch] = d1;
        else for (int i = 0; i < 16; i++) press[i] = d1;
      mpevt_pkg::StBend:
        bend[mode_mpe ? ch : 4'd0] = {d2, d1};
      mpevt_pkg::StCtrl: begin
        if (d1 == mpevt_pkg::CcAllOff) begin
          for (int i = 0; i < 16; i++) slide[i] = 0;
          nrpn_word = 0;
        end
        if (d1 == mpevt_pkg::CcSlide) slide[ch] = d2;
        if (d1 == mpevt_pkg::CcMod) modw[mode_mpe ? ch : 4'd0] = d2;
        else nrpn_step(ch, d1, d2);
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) mask[i] = gate[i];
    pending.push_back({mask, rep, note[rep], strike[rep], lift[rep], press[rep],
                       slide[rep], modw[rep], bend[rep], nrpn_word, led});
  endfunction

  function void check_result(bit [90:0] got);
    bit [90:0] e;
    string names[11] = '{"gate_mask", "slot", "note_out", "strike_out", "lift_out",
                         "press_out", "slide_out", "mod_out", "bend_out", "nrpn_value",
                         "nrpn_match"};
    int w[11] = '{16, 4, 7, 7, 7, 7, 7, 7, 14, 14, 1};
    int lo;
    if (pending.size() == 0) begin
      $error("result with no transfer pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    lo = 91;
    for (int f = 0; f < 11; f++) begin
      lo -= w[f];
      if (((e ^ got) >> lo) & ((91'd1 << w[f]) - 1)) begin
        $error("%s expected %0d got %0d", names[f],
               (e >> lo) & ((91'd1 << w[f]) - 1), (got >> lo) & ((91'd1 << w[f]) - 1));
        errors++;
      end
    end
  endfunction
endclass

module mpe_midi_voice_state_tracker_core_test;
  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic func = 0;
  logic [3:0] status = 0, midi_channel = 0;
  logic [6:0] data1 = 0, data2 = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] gate_mask;
  logic [3:0] slot;
  logic [6:0] note_out, strike_out, lift_out, press_out, slide_out, mod_out;
  logic [13:0] bend_out, nrpn_value;
  logic nrpn_match;

  voice_tracker_board board;
  int stall_count = 0;

  mpe_midi_voice_state_tracker_core u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_item(func, status, midi_channel, data1, data2);
      if (out_valid && out_ready)
        board.check_result({gate_mask, slot, note_out, strike_out, lift_out, press_out,
                            slide_out, mod_out, bend_out, nrpn_value, nrpn_match});
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_count = 0;
      else stall_count++;
      if (stall_count >= 2000) begin
        $display("mpe_midi_voice_state_tracker_core regression: fail");
        $finish;
      end
    end
  end

  // randomize result-side backpressure
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(input bit [0:0] idx, input bit [31:0] value);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    if (idx == mpevt_pkg::AddrMode) board.mode_mpe = value[0];
    else board.nrpn_sel = value[13:0];
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic send_msg(input bit f, input bit [3:0] st, input bit [3:0] ch,
                          input bit [6:0] d1, input bit [6:0] d2, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    func <= f;
    status <= st;
    midi_channel <= ch;
    data1 <= d1;
    data2 <= d2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_nrpn(input bit [13:0] num, input bit [13:0] word, input bit burst);
    send_msg(0, mpevt_pkg::StCtrl, 0, mpevt_pkg::CcNrpnMsb, num[13:7], burst);
    send_msg(0, mpevt_pkg::StCtrl, 0, mpevt_pkg::CcNrpnLsb, num[6:0], burst);
    send_msg(0, mpevt_pkg::StCtrl, 0, mpevt_pkg::CcDataMsb, word[13:7], burst);
    send_msg(0, mpevt_pkg::StCtrl, 0, mpevt_pkg::CcDataLsb, word[6:0], burst);
  endtask

  task automatic random_phase(input int count);
    bit [3:0] codes[6] = '{mpevt_pkg::StNoteOff, mpevt_pkg::StNoteOn,
                           mpevt_pkg::StPolyPress, mpevt_pkg::StCtrl,
                           mpevt_pkg::StChanPress, mpevt_pkg::StBend};
    bit [6:0] ccs[8] = '{mpevt_pkg::CcAllOff, mpevt_pkg::CcSlide, mpevt_pkg::CcMod,
                         mpevt_pkg::CcNrpnMsb, mpevt_pkg::CcNrpnLsb,
                         mpevt_pkg::CcDataMsb, mpevt_pkg::CcDataLsb, 7'd0};
    bit [3:0] st;
    bit [6:0] d1;
    bit burst;
    int sel;
    for (int n = 0; n < count; n++) begin
      burst = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 19);
      st = codes[$urandom_range(0, 5)];
      d1 = 7'($urandom_range(0, 127));
      if (sel < 2) begin
        send_nrpn($urandom_range(0, 1) ? board.nrpn_sel : 14'($urandom),
                  14'($urandom), burst);
        n += 3;
      end else if (sel < 4)
        send_msg(1, 4'($urandom), 4'($urandom), 7'($urandom), 7'($urandom), burst);
      else if (sel == 4)
        send_msg(0, 4'($urandom), 4'($urandom), 7'($urandom), 7'($urandom), burst);
      else begin
        if (st == mpevt_pkg::StCtrl) begin
          d1 = ccs[$urandom_range(0, 7)];
          if (d1 == 0) d1 = 7'($urandom_range(0, 127));
        end else if (st != mpevt_pkg::StBend && st != mpevt_pkg::StChanPress)
          d1 = 7'($urandom_range(56, 72));
        send_msg(0, st, ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom), d1,
                 7'($urandom_range(0, 127)), burst);
      end
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_msg(1, 0, 0, 0, 0, 0);
    send_msg(0, mpevt_pkg::StNoteOn, 0, 0, 127, 0);
    send_msg(0, mpevt_pkg::StNoteOn, 15, 127, 1, 0);
    send_msg(0, mpevt_pkg::StPolyPress, 15, 127, 127, 0);
    send_msg(0, mpevt_pkg::StChanPress, 0, 127, 0, 0);
    send_msg(0, mpevt_pkg::StBend, 15, 127, 127, 0);
    send_msg(0, mpevt_pkg::StBend, 0, 0, 0, 0);
    send_msg(0, mpevt_pkg::StCtrl, 15, mpevt_pkg::CcSlide, 127, 0);
    send_msg(0, mpevt_pkg::StCtrl, 15, mpevt_pkg::CcMod, 127, 0);
    send_msg(0, mpevt_pkg::StCtrl, 3, mpevt_pkg::CcAllOff, 0, 0);
    send_msg(0, mpevt_pkg::StNoteOn, 0, 0, 0, 0);
    send_msg(0, mpevt_pkg::StNoteOff, 15, 127, 127, 0);
    send_msg(0, 4'h0, 15, 127, 127, 0);
    send_msg(0, 4'hF, 5, 1, 1, 0);
    send_msg(1, 0, 15, 127, 127, 0);
    send_nrpn(14'd1, 14'h3FFF, 0);
    send_nrpn(14'd2, 14'h1234, 0);
    send_msg(0, mpevt_pkg::StCtrl, 1, mpevt_pkg::CcNrpnMsb, 0, 0);
    drain();

    write_reg(mpevt_pkg::AddrMode, 0);
    write_reg(mpevt_pkg::AddrSelect, 32'h3FFF);
    for (int i = 0; i < 17; i++)
      send_msg(0, mpevt_pkg::StNoteOn, 4'(i), 7'(40 + i), 7'(1 + i), 1);
    send_nrpn(14'h3FFF, 14'h0155, 0);
    random_phase(300);
    drain();

    write_reg(mpevt_pkg::AddrMode, 1);
    write_reg(mpevt_pkg::AddrSelect, 0);
    random_phase(350);
    drain();

    write_reg(mpevt_pkg::AddrMode, 0);
    write_reg(mpevt_pkg::AddrSelect, 32'h2A55);
    random_phase(350);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("mpe_midi_voice_state_tracker_core regression: pass");
    else
      $display("mpe_midi_voice_state_tracker_core regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

FILE: mpe_midi_voice_state_tracker_core.f
+incdir+rtl/core
rtl/core/mpevt_pkg.sv
rtl/core/mpevt_ctrl.sv
rtl/core/mpevt_dp.sv
rtl/core/mpe_midi_voice_state_tracker_core.sv
sim/mpe_midi_voice_state_tracker_core_test.sv
